// ===== hw/rtl/tclp_pkg.sv =====
// Shared types, constants and keyword table for the command line parser.
`default_nettype none

package tclp_pkg;

  // Character position counter saturates here; all long lines look alike.
  localparam int unsigned POS_SAT = 15;
  localparam int unsigned POS_W   = $clog2(POS_SAT + 1);

  localparam int unsigned PERIOD_W = 31;
  localparam logic [PERIOD_W-1:0] PERIOD_MAX   = {PERIOD_W{1'b1}};
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(1);
  localparam logic                SCALE_RESET  = 1'b1;

  localparam int unsigned CFG_INDEX_W = 8;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_START_PERIOD     = CFG_INDEX_W'(0),
    REG_START_FAHRENHEIT = CFG_INDEX_W'(1)
  } reg_index_t;

  localparam logic [7:0] CHAR_NEWLINE = 8'd10;
  localparam logic [7:0] CHAR_F       = "F";
  localparam logic [7:0] CHAR_C       = "C";
  localparam logic [7:0] CHAR_ZERO    = "0";
  localparam logic [7:0] CHAR_NINE    = "9";

  // Keyword order: OFF, LOG, STOP, START, SCALE=, PERIOD=.
  localparam int unsigned NUM_KEYS = 6;
  localparam int unsigned KEY_OFF    = 0;
  localparam int unsigned KEY_LOG    = 1;
  localparam int unsigned KEY_STOP   = 2;
  localparam int unsigned KEY_START  = 3;
  localparam int unsigned KEY_SCALE  = 4;
  localparam int unsigned KEY_PERIOD = 5;

  localparam logic [7:0] KEY_TEXT [NUM_KEYS][8] = '{
    '{"O", "F", "F", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"L", "O", "G", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"S", "T", "O", "P", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"S", "T", "A", "R", "T", 8'h00, 8'h00, 8'h00},
    '{"S", "C", "A", "L", "E", "=", 8'h00, 8'h00},
    '{"P", "E", "R", "I", "O", "D", "=", 8'h00}
  };

  localparam logic [POS_W-1:0] KEY_LEN [NUM_KEYS] = '{
    POS_W'(3), POS_W'(3), POS_W'(4), POS_W'(5), POS_W'(6), POS_W'(7)
  };

  typedef enum logic [2:0] {
    CMD_INVALID = 3'd0,
    CMD_OFF     = 3'd1,
    CMD_LOG     = 3'd2,
    CMD_STOP    = 3'd3,
    CMD_START   = 3'd4,
    CMD_SCALE   = 3'd5,
    CMD_PERIOD  = 3'd6
  } cmd_t;

  typedef struct packed {
    cmd_t                command;
    logic                fahrenheit;
    logic [PERIOD_W-1:0] period_value;
    logic                running;
  } result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/tclp_matcher.sv =====
// Per-character keyword matcher, digit accumulator and command decision.
`default_nettype none

module tclp_matcher (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 take,
  input  wire logic [7:0]                           rx_byte,
  input  wire logic                                 cfg_write,
  input  wire logic [tclp_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  wire logic [tclp_pkg::PERIOD_W-1:0]        cfg_data,
  output      logic                                 result_valid,
  output      tclp_pkg::result_t                    result
);

  logic [tclp_pkg::POS_W-1:0]    char_position, char_position_next;
  logic [tclp_pkg::NUM_KEYS-1:0] keyword_alive, keyword_alive_next;
  logic                          scale_letter_ok, scale_letter_ok_next;
  logic                          scale_letter_is_f, scale_letter_is_f_next;
  logic                          digits_all_valid, digits_all_valid_next;
  logic [tclp_pkg::PERIOD_W-1:0] period_accum, period_accum_next;
  logic [tclp_pkg::PERIOD_W-1:0] period_reg, period_reg_next;
  logic                          scale_reg, scale_reg_next;
  logic                          run_flag, run_flag_next;
  logic                          halted, halted_next;

  logic                          is_newline;
  logic                          is_digit;
  logic [3:0]                    digit;
  logic [tclp_pkg::PERIOD_W+3:0] accum_times_ten;
  tclp_pkg::cmd_t                cmd;

  assign is_newline = (rx_byte == tclp_pkg::CHAR_NEWLINE);
  assign is_digit   = (rx_byte >= tclp_pkg::CHAR_ZERO) && (rx_byte <= tclp_pkg::CHAR_NINE);
  assign digit      = 4'(rx_byte - tclp_pkg::CHAR_ZERO);

  // Times ten as two shifts and an add, then the new digit.
  assign accum_times_ten = {1'b0, period_accum, 3'b000} + {3'b000, period_accum, 1'b0}
                         + (tclp_pkg::PERIOD_W + 4)'(digit);

  always_comb begin
    char_position_next     = char_position;
    keyword_alive_next     = keyword_alive;
    scale_letter_ok_next   = scale_letter_ok;
    scale_letter_is_f_next = scale_letter_is_f;
    digits_all_valid_next  = digits_all_valid;
    period_accum_next      = period_accum;
    period_reg_next        = period_reg;
    scale_reg_next         = scale_reg;
    run_flag_next          = run_flag;
    halted_next            = halted;
    cmd                    = tclp_pkg::CMD_INVALID;

    if (take && !halted && !is_newline) begin
      for (int k = 0; k < tclp_pkg::NUM_KEYS; k++) begin
        if (char_position < tclp_pkg::KEY_LEN[k] &&
            rx_byte != tclp_pkg::KEY_TEXT[k][char_position[2:0]]) begin
          keyword_alive_next[k] = 1'b0;
        end
      end
      if (char_position == tclp_pkg::POS_W'(6)) begin
        scale_letter_ok_next   = (rx_byte == tclp_pkg::CHAR_F) ||
                                 (rx_byte == tclp_pkg::CHAR_C);
        scale_letter_is_f_next = (rx_byte == tclp_pkg::CHAR_F);
      end
      if (char_position >= tclp_pkg::POS_W'(7)) begin
        if (is_digit) begin
          if (accum_times_ten > (tclp_pkg::PERIOD_W + 4)'(tclp_pkg::PERIOD_MAX)) begin
            period_accum_next = tclp_pkg::PERIOD_MAX;
          end else begin
            period_accum_next = accum_times_ten[tclp_pkg::PERIOD_W-1:0];
          end
        end else begin
          digits_all_valid_next = 1'b0;
        end
      end
      if (char_position != tclp_pkg::POS_W'(tclp_pkg::POS_SAT)) begin
        char_position_next = char_position + tclp_pkg::POS_W'(1);
      end
    end

    if (take && !halted && is_newline) begin
      // Rules are tried in priority order; a shorter line than a rule needs
      // falls out as invalid before later rules are looked at.
      if (char_position < tclp_pkg::POS_W'(3)) begin
        cmd = tclp_pkg::CMD_INVALID;
      end else if (keyword_alive[tclp_pkg::KEY_OFF]) begin
        if (char_position == tclp_pkg::POS_W'(3)) begin
          cmd         = tclp_pkg::CMD_OFF;
          halted_next = 1'b1;
        end
      end else if (keyword_alive[tclp_pkg::KEY_LOG]) begin
        cmd = tclp_pkg::CMD_LOG;
      end else if (char_position < tclp_pkg::POS_W'(4)) begin
        cmd = tclp_pkg::CMD_INVALID;
      end else if (keyword_alive[tclp_pkg::KEY_STOP]) begin
        cmd           = tclp_pkg::CMD_STOP;
        run_flag_next = 1'b0;
      end else if (char_position < tclp_pkg::POS_W'(5)) begin
        cmd = tclp_pkg::CMD_INVALID;
      end else if (keyword_alive[tclp_pkg::KEY_START]) begin
        cmd           = tclp_pkg::CMD_START;
        run_flag_next = 1'b1;
      end else if (char_position < tclp_pkg::POS_W'(6)) begin
        cmd = tclp_pkg::CMD_INVALID;
      end else if (keyword_alive[tclp_pkg::KEY_SCALE]) begin
        if (char_position == tclp_pkg::POS_W'(7) && scale_letter_ok) begin
          cmd            = tclp_pkg::CMD_SCALE;
          scale_reg_next = scale_letter_is_f;
        end
      end else if (char_position < tclp_pkg::POS_W'(7)) begin
        cmd = tclp_pkg::CMD_INVALID;
      end else if (keyword_alive[tclp_pkg::KEY_PERIOD]) begin
        if (char_position >= tclp_pkg::POS_W'(8) && digits_all_valid) begin
          cmd             = tclp_pkg::CMD_PERIOD;
          period_reg_next = period_accum;
        end
      end

      char_position_next     = '0;
      keyword_alive_next     = '1;
      scale_letter_ok_next   = 1'b0;
      scale_letter_is_f_next = 1'b0;
      digits_all_valid_next  = 1'b1;
      period_accum_next      = '0;
    end

    if (cfg_write) begin
      unique case (cfg_index)
        tclp_pkg::REG_START_PERIOD:     period_reg_next = cfg_data;
        tclp_pkg::REG_START_FAHRENHEIT: scale_reg_next  = cfg_data[0];
        default: ;
      endcase
    end
  end

  assign result_valid        = take && !halted && is_newline;
  assign result.command      = cmd;
  assign result.fahrenheit   = scale_reg_next;
  assign result.period_value = period_reg_next;
  assign result.running      = run_flag_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      char_position     <= '0;
      keyword_alive     <= '1;
      scale_letter_ok   <= 1'b0;
      scale_letter_is_f <= 1'b0;
      digits_all_valid  <= 1'b1;
      period_accum      <= '0;
      period_reg        <= tclp_pkg::PERIOD_RESET;
      scale_reg         <= tclp_pkg::SCALE_RESET;
      run_flag          <= 1'b1;
      halted            <= 1'b0;
    end else begin
      char_position     <= char_position_next;
      keyword_alive     <= keyword_alive_next;
      scale_letter_ok   <= scale_letter_ok_next;
      scale_letter_is_f <= scale_letter_is_f_next;
      digits_all_valid  <= digits_all_valid_next;
      period_accum      <= period_accum_next;
      period_reg        <= period_reg_next;
      scale_reg         <= scale_reg_next;
      run_flag          <= run_flag_next;
      halted            <= halted_next;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/text_command_line_parser.sv =====
// Top level of the text command line parser: matcher plus result skid stage.
//
// Usage: received characters enter one per transaction on the rx channel
// (rx_valid, rx_stall, rx_byte). Ordinary characters update the line state
// and give no result. A newline ends the line and produces one result
// transaction on the res channel (res_valid, res_stall) carrying the command
// code and the scale, period and running state as they stand after the line.
// The block takes one character per cycle while rx_stall is low; a newline's
// result is registered. The matcher works in a single pass per character:
// its flags and the times-ten period accumulator update in the same cycle.
// When the receiver stalls, the result register holds its transaction and a
// one-entry skid register takes the next result; rx_stall rises only while
// that skid register is full. After OFF every later character is absorbed
// with no result until reset. The configuration channel (cfg_valid,
// cfg_ready, cfg_index, cfg_data) is always ready and loads the period or
// scale at once. Synchronous reset restores period 1, Fahrenheit, running,
// and an empty line.
`default_nettype none

module text_command_line_parser (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 rx_valid,
  output      logic                                 rx_stall,
  input  wire logic [7:0]                           rx_byte,
  output      logic                                 res_valid,
  input  wire logic                                 res_stall,
  output      logic [2:0]                           command,
  output      logic                                 fahrenheit,
  output      logic [tclp_pkg::PERIOD_W-1:0]        period_value,
  output      logic                                 running,
  input  wire logic                                 cfg_valid,
  output      logic                                 cfg_ready,
  input  wire logic [tclp_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  wire logic [tclp_pkg::PERIOD_W-1:0]        cfg_data
);

  logic              take;
  logic              m_valid;
  tclp_pkg::result_t m_result;
  tclp_pkg::result_t res_q;
  logic              skid_valid;
  tclp_pkg::result_t skid_q;

  assign cfg_ready = 1'b1;
  assign rx_stall  = skid_valid;
  assign take      = rx_valid && !rx_stall;

  tclp_matcher u_matcher (
    .clk          (clk),
    .rst          (rst),
    .take         (take),
    .rx_byte      (rx_byte),
    .cfg_write    (cfg_valid && cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .result_valid (m_valid),
    .result       (m_result)
  );

  // Output register with a skid entry. A new result can only arrive while
  // the skid entry is empty, since rx_stall is high whenever it is full.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!res_valid || !res_stall) begin
      if (skid_valid) begin
        res_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        res_valid <= m_valid;
      end
    end else if (m_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!res_valid || !res_stall) begin
      if (skid_valid) begin
        res_q <= skid_q;
      end else if (m_valid) begin
        res_q <= m_result;
      end
    end else if (m_valid) begin
      skid_q <= m_result;
    end
  end

  assign command      = res_q.command;
  assign fahrenheit   = res_q.fahrenheit;
  assign period_value = res_q.period_value;
  assign running      = res_q.running;

  // The skid entry is only ever filled behind a held result.
  a_skid_behind_result: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> res_valid)
    else $error("skid entry full while result register empty");

  // The skid entry fills only when the result register was stalled.
  a_skid_fill_on_stall: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(res_valid && res_stall))
    else $error("skid entry filled without a stalled result");

  // Once OFF has been reported, no further result is produced.
  a_silent_after_off: assert property (@(posedge clk) disable iff (rst)
    (m_valid && m_result.command == tclp_pkg::CMD_OFF) |=> !m_valid)
    else $error("result produced after OFF");

endmodule

`default_nettype wire
